// ===== hw/rtl/hirc_pkg.sv =====
// ----------------------------------------------------------------------------
// hirc_pkg: shared widths, codes and types of the height-indexed ring cache
// Ring geometry, operation and status codes, and the structs passed between
// the sequencer, the key memory and the result buffer.
// ----------------------------------------------------------------------------
package hirc_pkg;

  // Ring size is a power of two so that ring arithmetic is a plain wrap.
  localparam int IDX_W    = 4;
  localparam int CAPACITY = 1 << IDX_W;
  localparam int CNT_W    = IDX_W + 1;

  localparam int HEIGHT_W = 32;
  localparam int KEY_W    = 64;
  localparam int OP_W     = 3;
  localparam int STAT_W   = 3;

  localparam logic [OP_W-1:0] OP_ADD    = 3'd0;
  localparam logic [OP_W-1:0] OP_REVERT = 3'd1;
  localparam logic [OP_W-1:0] OP_GET    = 3'd2;
  localparam logic [OP_W-1:0] OP_GET_NN = 3'd3;
  localparam logic [OP_W-1:0] OP_BEST   = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_NOT_ABOVE = 3'd1;
  localparam logic [STAT_W-1:0] ST_MISMATCH  = 3'd2;
  localparam logic [STAT_W-1:0] ST_ABOVE     = 3'd3;
  localparam logic [STAT_W-1:0] ST_FETCH_EXT = 3'd4;

  typedef struct packed {
    logic [STAT_W-1:0]   status;
    logic                present;
    logic [KEY_W-1:0]    key;
    logic [HEIGHT_W-1:0] height;
  } res_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [KEY_W-1:0] wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } ram_req_t;

endpackage

// ===== hw/rtl/hirc_key_ram.sv =====
// ----------------------------------------------------------------------------
// hirc_key_ram: key store of the ring
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module hirc_key_ram (
  input  logic                     clk_i,
  input  hirc_pkg::ram_req_t       req_i,
  output logic [hirc_pkg::KEY_W-1:0] rdata_o
);

  logic [hirc_pkg::KEY_W-1:0] mem_q [hirc_pkg::CAPACITY];
  logic [hirc_pkg::KEY_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/hirc_seq.sv =====
// ----------------------------------------------------------------------------
// hirc_seq: operation sequencer and ring bookkeeping
// Holds head index, head height, fill count and the per-slot present bits,
// and steps through the slots for revert, tail search and upward walks.
// ----------------------------------------------------------------------------
module hirc_seq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [hirc_pkg::OP_W-1:0]     operation_i,
  input  logic [hirc_pkg::HEIGHT_W-1:0] item_height_i,
  input  logic [hirc_pkg::KEY_W-1:0]    item_key_i,
  output hirc_pkg::ram_req_t            ram_req_o,
  input  logic [hirc_pkg::KEY_W-1:0]    ram_rdata_i,
  output logic                          res_valid_o,
  input  logic                          res_take_i,
  output hirc_pkg::res_t                res_o
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_REV_RD   = 3'd1;
  localparam logic [2:0] S_REV_WALK = 3'd2;
  localparam logic [2:0] S_PROBE    = 3'd3;
  localparam logic [2:0] S_TAIL     = 3'd4;
  localparam logic [2:0] S_UP       = 3'd5;
  localparam logic [2:0] S_KEY_RD   = 3'd6;
  localparam logic [2:0] S_DONE     = 3'd7;

  logic [2:0]                    state_q, state_d;
  logic [hirc_pkg::OP_W-1:0]     op_q, op_d;
  logic [hirc_pkg::HEIGHT_W-1:0] h_q, h_d;
  logic [hirc_pkg::KEY_W-1:0]    key_q, key_d;
  logic [hirc_pkg::IDX_W-1:0]    ptr_q, ptr_d;
  logic [hirc_pkg::IDX_W-1:0]    base_q, base_d;
  logic [hirc_pkg::CNT_W-1:0]    cnt_q, cnt_d;
  logic [hirc_pkg::IDX_W-1:0]    head_idx_q, head_idx_d;
  logic [hirc_pkg::HEIGHT_W-1:0] head_h_q, head_h_d;
  logic [hirc_pkg::CNT_W-1:0]    fill_q, fill_d;
  logic [hirc_pkg::CAPACITY-1:0] present_q, present_d;
  hirc_pkg::res_t                res_q, res_d;

  // Add datapath
  logic                          add_empty;
  logic [hirc_pkg::HEIGHT_W-1:0] add_diff;
  logic                          add_long;
  logic [hirc_pkg::CNT_W-1:0]    add_len;
  logic [hirc_pkg::IDX_W-1:0]    add_step;
  logic [hirc_pkg::IDX_W-1:0]    add_head;
  logic [hirc_pkg::IDX_W-1:0]    add_gap;
  logic [hirc_pkg::CNT_W:0]      add_fill_sum;
  logic [hirc_pkg::CNT_W-1:0]    add_fill;
  logic [hirc_pkg::CAPACITY-1:0] add_present;

  // Lookup start
  logic [hirc_pkg::HEIGHT_W-1:0] q_dist;
  logic                          ring_empty;
  logic                          tail_last;

  assign ring_empty   = (fill_q == '0);
  assign add_empty    = ring_empty;
  assign add_diff     = item_height_i - head_h_q;
  assign add_long     = !add_empty && (add_diff > hirc_pkg::HEIGHT_W'(hirc_pkg::CAPACITY));
  assign add_len      = add_empty ? hirc_pkg::CNT_W'(1) : add_diff[hirc_pkg::CNT_W-1:0];
  assign add_step     = add_empty ? hirc_pkg::IDX_W'(1) : add_diff[hirc_pkg::IDX_W-1:0];
  assign add_head     = head_idx_q + add_step;
  assign add_gap      = hirc_pkg::IDX_W'(add_len - hirc_pkg::CNT_W'(1));
  assign add_fill_sum = {1'b0, fill_q} + {1'b0, add_len};
  assign add_fill     = (add_long ||
                         (add_fill_sum > (hirc_pkg::CNT_W+1)'(hirc_pkg::CAPACITY)))
                        ? hirc_pkg::CNT_W'(hirc_pkg::CAPACITY)
                        : add_fill_sum[hirc_pkg::CNT_W-1:0];

  assign q_dist    = head_h_q - item_height_i;
  assign tail_last = ((cnt_q + hirc_pkg::CNT_W'(1)) == fill_q);

  // Clear the skipped slots (or all of them on a long gap), then mark the new head.
  always_comb begin
    logic [hirc_pkg::IDX_W-1:0] offs;
    add_present = present_q;
    for (int i = 0; i < hirc_pkg::CAPACITY; i++) begin
      offs = hirc_pkg::IDX_W'(i) - head_idx_q;
      if (add_long || (offs != '0 && offs <= add_gap)) begin
        add_present[i] = 1'b0;
      end
    end
    add_present[add_head] = 1'b1;
  end

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    h_d        = h_q;
    key_d      = key_q;
    ptr_d      = ptr_q;
    base_d     = base_q;
    cnt_d      = cnt_q;
    head_idx_d = head_idx_q;
    head_h_d   = head_h_q;
    fill_d     = fill_q;
    present_d  = present_q;
    res_d      = res_q;
    ram_req_o  = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d  = operation_i;
          h_d   = item_height_i;
          key_d = item_key_i;
          res_d = '0;
          case (operation_i)
            hirc_pkg::OP_ADD: begin
              state_d = S_DONE;
              if (!ring_empty && item_height_i <= head_h_q) begin
                res_d.status = hirc_pkg::ST_NOT_ABOVE;
              end else begin
                head_idx_d      = add_head;
                head_h_d        = item_height_i;
                fill_d          = add_fill;
                present_d       = add_present;
                ram_req_o.we    = 1'b1;
                ram_req_o.waddr = add_head;
                ram_req_o.wdata = item_key_i;
              end
            end
            hirc_pkg::OP_REVERT: begin
              if (ring_empty) begin
                state_d = S_DONE;
              end else begin
                ram_req_o.re    = 1'b1;
                ram_req_o.raddr = head_idx_q;
                state_d         = S_REV_RD;
              end
            end
            hirc_pkg::OP_GET, hirc_pkg::OP_GET_NN: begin
              state_d = S_DONE;
              if (ring_empty) begin
                res_d.status = hirc_pkg::ST_FETCH_EXT;
                res_d.height = item_height_i;
              end else if (item_height_i > head_h_q) begin
                res_d.status = hirc_pkg::ST_ABOVE;
              end else if (q_dist >= hirc_pkg::HEIGHT_W'(fill_q)) begin
                res_d.status = hirc_pkg::ST_FETCH_EXT;
                res_d.height = item_height_i;
              end else begin
                ptr_d   = head_idx_q - q_dist[hirc_pkg::IDX_W-1:0];
                base_d  = head_idx_q - q_dist[hirc_pkg::IDX_W-1:0];
                cnt_d   = q_dist[hirc_pkg::CNT_W-1:0];
                state_d = S_PROBE;
              end
            end
            hirc_pkg::OP_BEST: begin
              if (ring_empty) begin
                res_d.status = hirc_pkg::ST_FETCH_EXT;
                state_d      = S_DONE;
              end else begin
                h_d             = head_h_q;
                ram_req_o.re    = 1'b1;
                ram_req_o.raddr = head_idx_q;
                state_d         = S_KEY_RD;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      S_REV_RD: begin
        if (ram_rdata_i != key_q) begin
          res_d.status = hirc_pkg::ST_MISMATCH;
          state_d      = S_DONE;
        end else begin
          present_d[head_idx_q] = 1'b0;
          head_idx_d            = head_idx_q - hirc_pkg::IDX_W'(1);
          head_h_d              = head_h_q - hirc_pkg::HEIGHT_W'(1);
          fill_d                = fill_q - hirc_pkg::CNT_W'(1);
          state_d               = S_REV_WALK;
        end
      end

      // Drop empty slots below the removed head, one per cycle.
      S_REV_WALK: begin
        if (!ring_empty && !present_q[head_idx_q]) begin
          head_idx_d = head_idx_q - hirc_pkg::IDX_W'(1);
          head_h_d   = head_h_q - hirc_pkg::HEIGHT_W'(1);
          fill_d     = fill_q - hirc_pkg::CNT_W'(1);
        end else begin
          state_d = S_DONE;
        end
      end

      S_PROBE: begin
        if (present_q[ptr_q]) begin
          ram_req_o.re    = 1'b1;
          ram_req_o.raddr = ptr_q;
          state_d         = S_KEY_RD;
        end else if (tail_last) begin
          res_d.status = hirc_pkg::ST_FETCH_EXT;
          res_d.height = h_q;
          state_d      = S_DONE;
        end else begin
          ptr_d   = ptr_q - hirc_pkg::IDX_W'(1);
          cnt_d   = cnt_q + hirc_pkg::CNT_W'(1);
          state_d = S_TAIL;
        end
      end

      // Look for any filled slot older than the queried one.
      S_TAIL: begin
        if (present_q[ptr_q]) begin
          if (op_q == hirc_pkg::OP_GET) begin
            res_d.height = h_q;
            state_d      = S_DONE;
          end else begin
            ptr_d   = base_q + hirc_pkg::IDX_W'(1);
            h_d     = h_q + hirc_pkg::HEIGHT_W'(1);
            state_d = S_UP;
          end
        end else if (tail_last) begin
          res_d.status = hirc_pkg::ST_FETCH_EXT;
          res_d.height = h_q;
          state_d      = S_DONE;
        end else begin
          ptr_d = ptr_q - hirc_pkg::IDX_W'(1);
          cnt_d = cnt_q + hirc_pkg::CNT_W'(1);
        end
      end

      // Head is always filled, so this walk stops at the head at the latest.
      S_UP: begin
        if (present_q[ptr_q]) begin
          ram_req_o.re    = 1'b1;
          ram_req_o.raddr = ptr_q;
          state_d         = S_KEY_RD;
        end else begin
          ptr_d = ptr_q + hirc_pkg::IDX_W'(1);
          h_d   = h_q + hirc_pkg::HEIGHT_W'(1);
        end
      end

      S_KEY_RD: begin
        res_d.status  = hirc_pkg::ST_OK;
        res_d.present = 1'b1;
        res_d.key     = ram_rdata_i;
        res_d.height  = h_q;
        state_d       = S_DONE;
      end

      S_DONE: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      head_idx_q <= '0;
      head_h_q   <= '0;
      fill_q     <= '0;
      present_q  <= '0;
    end else begin
      state_q    <= state_d;
      head_idx_q <= head_idx_d;
      head_h_q   <= head_h_d;
      fill_q     <= fill_d;
      present_q  <= present_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    h_q    <= h_d;
    key_q  <= key_d;
    ptr_q  <= ptr_d;
    base_q <= base_d;
    cnt_q  <= cnt_d;
    res_q  <= res_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;

endmodule

// ===== hw/rtl/hirc_out_buf.sv =====
// ----------------------------------------------------------------------------
// hirc_out_buf: result register
// Holds one result beat towards the consumer and decouples its stall.
// ----------------------------------------------------------------------------
module hirc_out_buf (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  hirc_pkg::res_t res_i,
  output logic           take_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output hirc_pkg::res_t res_o
);

  logic           full_q, full_d;
  hirc_pkg::res_t data_q;
  logic           load;

  // Take a new beat when empty or while the held one leaves.
  assign take_o = !full_q || !out_stall_i;
  assign load   = push_i && take_o;

  always_comb begin
    full_d = full_q;
    if (load) begin
      full_d = 1'b1;
    end else if (full_q && !out_stall_i) begin
      full_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else begin
      full_q <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= res_i;
    end
  end

  assign out_valid_o = full_q;
  assign res_o       = data_q;

endmodule

// ===== hw/rtl/height_indexed_ring_cache.sv =====
// ----------------------------------------------------------------------------
// height_indexed_ring_cache: ring of slots indexed by consecutive height
// Add, revert, get, get-first-filled and best over a ring of CAPACITY slots,
// with keys in a synchronous memory and slot occupancy in flip-flops.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-----------------------------
//  in      | input     | in_valid_i / in_stall_o | operation, item_height,
//          |           |                        | item_key
//  out     | output    | out_valid_o / out_stall_i | status, present,
//          |           |                        | result_key, result_height
//
//  Per beat, the sequencer steps one slot per cycle through the present bits
//  for revert, get and get-first-filled, and reads the key memory, whose read
//  data is registered, for best, for the revert key compare and for a lookup
//  that returns a key.
//  Reset clears the present bits, head and fill count at once; the key memory
//  is not cleared, as keys are read only from filled slots.
//  A stalled result waits in the output register while the sequencer takes
//  and works on the next beat; the sequencer then holds its own result.
//  The key memory is never read and written in the same cycle, as one beat
//  is in flight at a time, so it needs no forwarding.
//
module height_indexed_ring_cache (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [hirc_pkg::OP_W-1:0]     operation_i,
  input  logic [hirc_pkg::HEIGHT_W-1:0] item_height_i,
  input  logic [hirc_pkg::KEY_W-1:0]    item_key_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [hirc_pkg::STAT_W-1:0]   status_o,
  output logic                          present_o,
  output logic [hirc_pkg::KEY_W-1:0]    result_key_o,
  output logic [hirc_pkg::HEIGHT_W-1:0] result_height_o
);

  hirc_pkg::ram_req_t         ram_req;
  logic [hirc_pkg::KEY_W-1:0] ram_rdata;
  logic                       res_valid;
  logic                       res_take;
  hirc_pkg::res_t             res_seq;
  hirc_pkg::res_t             res_out;

  // Key store: written on add, read for revert compare and lookups.
  hirc_key_ram u_key_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  // Sequencer: ring bookkeeping and slot walks.
  hirc_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation_i),
    .item_height_i (item_height_i),
    .item_key_i    (item_key_i),
    .ram_req_o     (ram_req),
    .ram_rdata_i   (ram_rdata),
    .res_valid_o   (res_valid),
    .res_take_i    (res_take),
    .res_o         (res_seq)
  );

  // Result register: holds the beat while the consumer stalls.
  hirc_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .res_i       (res_seq),
    .take_o      (res_take),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res_out)
  );

  assign status_o        = res_out.status;
  assign present_o       = res_out.present;
  assign result_key_o    = res_out.key;
  assign result_height_o = res_out.height;

endmodule
